/* hdl/mcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared types and constants for the motor command parser and duty generator.
// ----------------------------------------------------------------------------
package mcp_pkg;

    localparam logic [7:0]         HEADER_BYTE = 8'hFF;
    localparam logic [7:0]         ID_MOTOR_A  = 8'hFA;
    localparam logic [7:0]         ID_MOTOR_B  = 8'hFB;

    localparam int                 CMD_W       = 15;
    localparam int                 MAG_W       = 14;
    localparam logic signed [15:0] CMD_LIMIT   = 16'sd10000;
    localparam int                 FULL_SCALE  = 10000;
    localparam int                 HALF_SCALE  = FULL_SCALE / 2;

    localparam int                 QUEUE_DEPTH = 4;
    localparam int                 QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int                 QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int                 CFG_ADDR_W  = 3;
    localparam logic               REG_PWM_MAX = 1'b0;

    typedef struct packed {
        logic                    motor;
        logic signed [CMD_W-1:0] cmd;
        logic [MAG_W-1:0]        mag;
        logic                    neg;
    } t_frame;

endpackage

/* hdl/motor_command_parser_pwm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_parser_pwm
// Motor command frame parser with half-bridge duty generation and an
// APB-style register for the full-scale duty count.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full (o_in_stall low);
//   the duty pipeline takes one frame per cycle unless i_out_stall holds it.
// Path: the byte that ends a frame is written to the queue, then passes the
//   scale multiply, reciprocal multiply and output registers.
// Reset: parser returns to header search, queue and pipeline empty,
//   pwm_max returns to 65535.
module motor_command_parser_pwm
    import mcp_pkg::*;
#(
    parameter int DUTY_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_rx_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_motor_select,
    output logic signed [CMD_W-1:0] o_command_centi_percent,
    output logic [DUTY_BITS-1:0]    o_forward_duty,
    output logic [DUTY_BITS-1:0]    o_reverse_duty,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic [16:0] CAP_WIDE = (17'd1 << DUTY_BITS) - 17'd1;
    localparam logic [15:0] CAP      = CAP_WIDE[15:0];

    logic [15:0]          r_pwm_max;
    logic [DUTY_BITS-1:0] full;
    logic                 q_push, q_full, q_valid, q_pop;
    t_frame               push_frame, head_frame;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PWM_MAX) ? {16'd0, r_pwm_max} : 32'd0;
    assign full   = (r_pwm_max < CAP) ? r_pwm_max[DUTY_BITS-1:0] : CAP[DUTY_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_max <= 16'hFFFF;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PWM_MAX)) begin
            r_pwm_max <= pwdata[15:0];
        end
    end

    mcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_frame    (push_frame)
    );

    mcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (push_frame),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_frame (head_frame)
    );

    mcp_back #(
        .DUTY_BITS (DUTY_BITS)
    ) u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_full                  (full),
        .i_q_valid               (q_valid),
        .i_frame                 (head_frame),
        .o_pop                   (q_pop),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_motor_select          (o_motor_select),
        .o_command_centi_percent (o_command_centi_percent),
        .o_forward_duty          (o_forward_duty),
        .o_reverse_duty          (o_reverse_duty)
    );

endmodule

/* hdl/mcp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_front
// Byte parser: finds header, motor id and command bytes, clamps the command
// and pushes one frame per complete command into the queue.
// ----------------------------------------------------------------------------
module mcp_front
    import mcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_frame     o_frame
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ID,
        PH_HIGH,
        PH_LOW
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_motor, n_motor;
    logic [7:0]         r_high, n_high;
    logic               accept;
    logic signed [15:0] raw;
    logic signed [15:0] clamped;
    logic signed [15:0] neg_clamped;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    always_comb begin
        n_phase = r_phase;
        n_motor = r_motor;
        n_high  = r_high;
        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_rx_byte == HEADER_BYTE) begin
                        n_phase = PH_ID;
                    end
                end
                PH_ID: begin
                    if (i_rx_byte inside {ID_MOTOR_A, ID_MOTOR_B}) begin
                        n_motor = (i_rx_byte == ID_MOTOR_B);
                        n_phase = PH_HIGH;
                    end else if (i_rx_byte == HEADER_BYTE) begin
                        n_phase = PH_ID;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HIGH: begin
                    n_high  = i_rx_byte;
                    n_phase = PH_LOW;
                end
                PH_LOW: begin
                    n_phase = PH_HEADER;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_comb begin
        raw = signed'({r_high, i_rx_byte});
        if (raw > CMD_LIMIT) begin
            clamped = CMD_LIMIT;
        end else if (raw < -CMD_LIMIT) begin
            clamped = -CMD_LIMIT;
        end else begin
            clamped = raw;
        end
        neg_clamped   = -clamped;
        o_frame.motor = r_motor;
        o_frame.cmd   = clamped[CMD_W-1:0];
        o_frame.neg   = clamped[15];
        o_frame.mag   = clamped[15] ? neg_clamped[MAG_W-1:0] : clamped[MAG_W-1:0];
        o_push        = accept && (r_phase == PH_LOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_motor <= 1'b0;
            r_high  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_motor <= n_motor;
            r_high  <= n_high;
        end
    end

endmodule

/* hdl/mcp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_queue
// Short frame queue between the parser and the duty pipeline.
// ----------------------------------------------------------------------------
module mcp_queue
    import mcp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_frame o_frame
);

    t_frame                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/mcp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_back
// Duty pipeline: scale the command magnitude by full scale, divide by the
// centi-percent span through a reciprocal multiply, and register the result.
// ----------------------------------------------------------------------------
module mcp_back
    import mcp_pkg::*;
#(
    parameter int DUTY_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [DUTY_BITS-1:0]    i_full,
    input  logic                    i_q_valid,
    input  t_frame                  i_frame,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_motor_select,
    output logic signed [CMD_W-1:0] o_command_centi_percent,
    output logic [DUTY_BITS-1:0]    o_forward_duty,
    output logic [DUTY_BITS-1:0]    o_reverse_duty
);

    localparam int          PROD_W   = MAG_W + DUTY_BITS;
    localparam int          RECIP_W  = PROD_W + 1;
    localparam int          RPROD_W  = PROD_W + RECIP_W;
    localparam int          SHIFT    = PROD_W + 14;
    localparam logic [63:0] RECIP_L  =
        ((64'd1 << SHIFT) + 64'(FULL_SCALE - 1)) / 64'(FULL_SCALE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

    logic               r_va;
    t_frame             r_fa;
    logic [PROD_W-1:0]  r_prod_a;
    logic               r_vb;
    t_frame             r_fb;
    logic [RPROD_W-1:0] r_prod_b;
    logic               r_vc;

    logic               ready_a, ready_b, ready_c;
    logic [PROD_W-1:0]  mag_ext, full_ext, rounded;
    logic [DUTY_BITS:0] quot;
    logic [DUTY_BITS:0] full_wide;
    logic [DUTY_BITS-1:0] duty;

    assign ready_c = !r_vc || !i_out_stall;
    assign ready_b = !r_vb || ready_c;
    assign ready_a = !r_va || ready_b;
    assign o_pop   = i_q_valid && ready_a;

    assign mag_ext   = PROD_W'(i_frame.mag);
    assign full_ext  = PROD_W'(i_full);
    assign rounded   = r_prod_a + PROD_W'(HALF_SCALE);
    assign quot      = r_prod_b[SHIFT +: DUTY_BITS + 1];
    assign full_wide = {1'b0, i_full};
    assign duty      = (quot > full_wide) ? i_full : quot[DUTY_BITS-1:0];

    assign o_out_valid = r_vc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ready_a) begin
                r_va <= i_q_valid;
            end
            if (ready_b) begin
                r_vb <= r_va;
            end
            if (ready_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_fa     <= i_frame;
            r_prod_a <= mag_ext * full_ext;
        end
        if (ready_b) begin
            r_fb     <= r_fa;
            r_prod_b <= RPROD_W'(rounded) * RPROD_W'(RECIP);
        end
        if (ready_c) begin
            o_motor_select          <= r_fb.motor;
            o_command_centi_percent <= r_fb.cmd;
            o_forward_duty          <= r_fb.neg ? '0 : duty;
            o_reverse_duty          <= r_fb.neg ? duty : '0;
        end
    end

`ifndef SYNTHESIS
    a_cmd_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_command_centi_percent >= -15'sd10000)
                        && (o_command_centi_percent <= 15'sd10000))
        else $error("command outside clamp range");

    a_neg_fwd_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_command_centi_percent[CMD_W-1]) |-> (o_forward_duty == '0))
        else $error("forward duty set on negative command");

    a_pos_rev_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_command_centi_percent[CMD_W-1]) |-> (o_reverse_duty == '0))
        else $error("reverse duty set on non-negative command");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motor_command_parser_pwm. Feeds a byte stream that
// is mostly well-formed command frames with random drive values, mixed with
// repeated headers, bad motor ids and loose noise bytes. The bench predicts
// each frame's motor, clamped command and bridge duties and checks every
// output item in order. It steps the full-scale register through zero, one,
// the maximum and random values, and applies random idle and stall bursts on
// both channels plus one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import mcp_pkg::*;

    localparam int          DUTY_BITS    = 16;
    localparam int unsigned DUTY_MAX     = (1 << DUTY_BITS) - 1;
    localparam int          SETTLE_TICKS = 10;
    localparam int          HOLD_TICKS   = 150;
    localparam int          PHASES       = 10;
    localparam int          PHASE_ITEMS  = 193;
    localparam int          DIR_ROWS     = 24;
    localparam logic [CFG_ADDR_W-1:0] ADDR_PWM_MAX = CFG_ADDR_W'(4 * REG_PWM_MAX);

    typedef enum logic [1:0] {SEEK_HEADER, SEEK_ID, TAKE_HIGH, TAKE_LOW} t_frame_phase;

    typedef struct packed {
        logic                    motor;
        logic signed [CMD_W-1:0] cmd;
        logic [DUTY_BITS-1:0]    fwd;
        logic [DUTY_BITS-1:0]    rev;
    } t_drive;

    typedef struct packed {
        logic [7:0] rx;
        logic       known;
        t_drive     want;
    } t_stim_row;

    localparam t_drive NO_DRIVE = '0;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    logic [7:0]              i_rx_byte   = 8'h00;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_motor_select;
    logic signed [CMD_W-1:0] o_command_centi_percent;
    logic [DUTY_BITS-1:0]    o_forward_duty;
    logic [DUTY_BITS-1:0]    o_reverse_duty;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr       = '0;
    logic [31:0]             pwdata      = '0;
    logic [31:0]             prdata;
    logic                    pready;

    t_frame_phase parse_state  = SEEK_HEADER;
    logic         motor_latch  = 1'b0;
    logic [7:0]   high_latch   = 8'h00;
    logic [15:0]  full_scale_q = 16'hFFFF;

    t_drive pending_drives[$];
    int     mismatches = 0;
    bit     idle_on    = 1'b1;
    bit     hold_req   = 1'b0;

    t_stim_row dir_tab [0:DIR_ROWS-1] = '{
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'hFA, 1'b0, NO_DRIVE},
        '{8'h27, 1'b0, NO_DRIVE},
        '{8'h10, 1'b1, '{1'b0, 15'sd10000, 16'hFFFF, 16'h0000}},
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'hFB, 1'b0, NO_DRIVE},
        '{8'h80, 1'b0, NO_DRIVE},
        '{8'h00, 1'b1, '{1'b1, -15'sd10000, 16'h0000, 16'hFFFF}},
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'hFA, 1'b0, NO_DRIVE},
        '{8'h7F, 1'b0, NO_DRIVE},
        '{8'hFF, 1'b1, '{1'b0, 15'sd10000, 16'hFFFF, 16'h0000}},
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'h12, 1'b0, NO_DRIVE},
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'hFB, 1'b0, NO_DRIVE},
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'h00, 1'b0, NO_DRIVE},
        '{8'hFF, 1'b0, NO_DRIVE},
        '{8'hFA, 1'b0, NO_DRIVE},
        '{8'h00, 1'b0, NO_DRIVE},
        '{8'h00, 1'b1, '{1'b0, 15'sd0, 16'h0000, 16'h0000}}
    };

    motor_command_parser_pwm #(
        .DUTY_BITS(DUTY_BITS)
    ) dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .o_in_stall              (o_in_stall),
        .i_rx_byte               (i_rx_byte),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_motor_select          (o_motor_select),
        .o_command_centi_percent (o_command_centi_percent),
        .o_forward_duty          (o_forward_duty),
        .o_reverse_duty          (o_reverse_duty),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit decode_byte(input logic [7:0] rx, output t_drive d);
        logic signed [15:0] raw;
        int                 cmd;
        int unsigned        mag;
        int unsigned        full;
        int unsigned        duty;
        d = NO_DRIVE;
        decode_byte = 1'b0;
        case (parse_state)
            SEEK_HEADER: begin
                if (rx == HEADER_BYTE) parse_state = SEEK_ID;
            end
            SEEK_ID: begin
                if (rx == ID_MOTOR_A || rx == ID_MOTOR_B) begin
                    motor_latch = (rx == ID_MOTOR_B);
                    parse_state = TAKE_HIGH;
                end else if (rx != HEADER_BYTE) begin
                    parse_state = SEEK_HEADER;
                end
            end
            TAKE_HIGH: begin
                high_latch  = rx;
                parse_state = TAKE_LOW;
            end
            default: begin
                raw  = {high_latch, rx};
                cmd  = int'(raw);
                if (cmd > CMD_LIMIT) cmd = CMD_LIMIT;
                if (cmd < -CMD_LIMIT) cmd = -CMD_LIMIT;
                mag  = (cmd < 0) ? -cmd : cmd;
                full = (full_scale_q < DUTY_MAX) ? full_scale_q : DUTY_MAX;
                duty = (mag * full + HALF_SCALE) / FULL_SCALE;
                if (duty > full) duty = full;
                d.motor = motor_latch;
                d.cmd   = cmd[CMD_W-1:0];
                d.fwd   = (cmd >= 0) ? duty[DUTY_BITS-1:0] : '0;
                d.rev   = (cmd < 0) ? duty[DUTY_BITS-1:0] : '0;
                parse_state = SEEK_HEADER;
                decode_byte = 1'b1;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] rx, input bit known = 1'b0,
                             input t_drive want = NO_DRIVE);
        t_drive d;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (decode_byte(rx, d)) pending_drives.push_back(known ? want : d);
    endtask

    task automatic write_pwm_max(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PWM_MAX;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        full_scale_q = value;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_command;
        int c;
        case ($urandom_range(0, 7))
            0:       c = $urandom_range(0, 65535);
            1:       c = ($urandom_range(0, 1) ? 10000 : -10000) + $urandom_range(0, 4) - 2;
            2:       c = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(10001, 32768);
            3:       c = $urandom_range(0, 2) - 1;
            default: c = $urandom_range(0, 20000) - 10000;
        endcase
        pick_command = c[15:0];
    endfunction

    task automatic send_traffic(input int target);
        int          sent;
        int          sel;
        logic [15:0] raw;
        sent = 0;
        while (sent < target) begin
            sel = $urandom_range(0, 19);
            if (sel < 15) begin
                raw = pick_command();
                send_byte(HEADER_BYTE);
                if ($urandom_range(0, 7) == 0) begin
                    send_byte(HEADER_BYTE);
                    sent += 1;
                end
                send_byte($urandom_range(0, 1) ? ID_MOTOR_B : ID_MOTOR_A);
                send_byte(raw[15:8]);
                send_byte(raw[7:0]);
                sent += 4;
            end else if (sel < 17) begin
                send_byte(HEADER_BYTE);
                send_byte(8'($urandom_range(0, 255)));
                sent += 2;
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end
        end
    endtask

    initial begin : out_stall_gen
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_TICKS) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_drive want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: motor=%0d cmd=%0d fwd=%0d rev=%0d",
                             o_motor_select, o_command_centi_percent,
                             o_forward_duty, o_reverse_duty);
            end else begin
                want = pending_drives.pop_front();
                if (o_motor_select !== want.motor || o_command_centi_percent !== want.cmd ||
                    o_forward_duty !== want.fwd || o_reverse_duty !== want.rev) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected motor=%0d cmd=%0d fwd=%0d rev=%0d, %s",
                                 want.motor, want.cmd, want.fwd, want.rev,
                                 $sformatf("got motor=%0d cmd=%0d fwd=%0d rev=%0d",
                                           o_motor_select, o_command_centi_percent,
                                           o_forward_duty, o_reverse_duty));
                end
            end
        end
    end

    initial begin : run
        logic [15:0] scale_set [0:6];
        logic [15:0] scale;
        scale_set = '{16'd0, 16'd1, 16'd65535, 16'd10000, 16'd3, 16'd5000, 16'hFFFE};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(dir_tab[r].rx, dir_tab[r].known, dir_tab[r].want);
        drain();
        for (int p = 0; p < PHASES; p++) begin
            scale = (p < 7) ? scale_set[p] : 16'($urandom_range(1, 65535));
            write_pwm_max(scale);
            if (p == 4) hold_req = 1'b1;
            if (p == PHASES - 1) idle_on = 1'b0;
            send_traffic(PHASE_ITEMS);
            drain();
        end
        if (pending_drives.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
